// ===== hdl/multi_algorithm_sorter_with_swap_count_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorter
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_ALGORITHM_SORTER_WITH_SWAP_COUNT_DEFINES_SVH
`define MULTI_ALGORITHM_SORTER_WITH_SWAP_COUNT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/msswc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorter package
// Types and fixed constants shared by the sorter modules.
// ----------------------------------------------------------------------------
package msswc_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned TALLY_W = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASCENDING = 2'd1;

	localparam logic [1:0] ALG_BUBBLE = 2'd0;
	localparam logic [1:0] ALG_SELECTION = 2'd1;

	typedef enum logic [10:0] {
		S_LOAD  = 11'b000_0000_0001,
		S_RDI   = 11'b000_0000_0010,
		S_GETI  = 11'b000_0000_0100,
		S_RDJ   = 11'b000_0000_1000,
		S_CMPJ  = 11'b000_0001_0000,
		S_ENDI  = 11'b000_0010_0000,
		S_SWAP  = 11'b000_0100_0000,
		S_ORD   = 11'b000_1000_0000,
		S_OUT   = 11'b001_0000_0000,
		S_HOLD  = 11'b010_0000_0000,
		S_SPARE = 11'b100_0000_0000
	} state_t;

endpackage

// ===== hdl/msswc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msswc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/multi_algorithm_sorter_with_swap_count.sv =====
// ----------------------------------------------------------------------------
// Sorter with exchange count
// Loading accepts one value per cycle. After the final value the set of n values
// is sorted by a selection pass through one comparator and one RAM port,
// preceded for bubble sort by an inversion-count pass over the same pairs;
// then each value is emitted in turn and held while the output stalls.
// Reset empties the set, clears the count and selects ascending bubble sort.
// ----------------------------------------------------------------------------
`include "multi_algorithm_sorter_with_swap_count_defines.svh"

module multi_algorithm_sorter_with_swap_count #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [msswc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [msswc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [msswc_pkg::VALUE_W-1:0]     value,
	input  logic                                     final_item,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [msswc_pkg::VALUE_W-1:0]     sorted_value,
	output logic [msswc_pkg::TALLY_W-1:0]            exchange_count,
	output logic                                     overflowed,
	output logic                                     last_out
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned VW = msswc_pkg::VALUE_W;
	localparam int unsigned TW = msswc_pkg::TALLY_W;

	msswc_pkg::state_t state_q;

	logic [1:0]    algorithm_q;
	logic          ascending_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [TW-1:0] tally_q;
	logic [AW-1:0] n_m1_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] best_q;
	logic [AW-1:0] k_q;
	logic          cnt_pass_q;
	logic [VW-1:0] vi_q;
	logic [VW-1:0] bv_q;
	logic [VW-1:0] out_value_q;
	logic          out_last_q;

	logic          in_xfer;
	logic          out_xfer;
	logic          full;
	logic [CW-1:0] n_new;
	logic [AW-1:0] idx;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [VW-1:0] wdata;
	logic [VW-1:0] rdata;
	logic [VW-1:0] cmp_ref;
	logic          precedes;
	logic          last_i;
	logic [TW-1:0] tally_inc;

	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign full = (fill_q == CW'(MAX_ITEMS));
	assign n_new = full ? fill_q : fill_q + CW'(1);
	assign last_i = ((i_q + AW'(1)) == n_m1_q);
	assign tally_inc = (tally_q == '1) ? tally_q : tally_q + TW'(1);
	assign cmp_ref = cnt_pass_q ? vi_q : bv_q;
	assign precedes = ascending_q ? ($signed(rdata) < $signed(cmp_ref))
		: ($signed(rdata) > $signed(cmp_ref));

	always_comb begin
		case (state_q)
			msswc_pkg::S_RDJ: idx = j_q;
			msswc_pkg::S_ORD: idx = k_q;
			default: idx = i_q;
		endcase
		raddr = n_m1_q - idx;
	end

	always_comb begin
		we = 1'b0;
		waddr = n_m1_q - i_q;
		wdata = bv_q;
		case (state_q)
			msswc_pkg::S_LOAD: begin
				we = in_xfer && !full;
				waddr = fill_q[AW-1:0];
				wdata = value;
			end
			msswc_pkg::S_ENDI: begin
				we = !cnt_pass_q && (best_q != i_q);
			end
			msswc_pkg::S_SWAP: begin
				we = 1'b1;
				waddr = n_m1_q - best_q;
				wdata = vi_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	msswc_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algorithm_q <= msswc_pkg::ALG_BUBBLE;
			ascending_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == msswc_pkg::REG_ALGORITHM) begin
				algorithm_q <= cfg_data[1:0];
			end else if (cfg_index == msswc_pkg::REG_ASCENDING) begin
				ascending_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msswc_pkg::S_LOAD;
			fill_q <= '0;
			ovf_q <= 1'b0;
			tally_q <= '0;
			cnt_pass_q <= 1'b0;
		end else begin
			case (state_q)
				msswc_pkg::S_LOAD: begin
					if (in_xfer) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
						if (final_item) begin
							n_m1_q <= AW'(n_new - CW'(1));
							i_q <= '0;
							k_q <= '0;
							cnt_pass_q <= (algorithm_q == msswc_pkg::ALG_BUBBLE);
							if (algorithm_q[1] && n_new > CW'(1)) begin
								tally_q <= TW'(n_new);
							end else begin
								tally_q <= '0;
							end
							state_q <= (n_new > CW'(1)) ? msswc_pkg::S_RDI
								: msswc_pkg::S_ORD;
						end
					end
				end
				msswc_pkg::S_RDI: begin
					state_q <= msswc_pkg::S_GETI;
				end
				msswc_pkg::S_GETI: begin
					vi_q <= rdata;
					bv_q <= rdata;
					best_q <= i_q;
					j_q <= i_q + AW'(1);
					state_q <= msswc_pkg::S_RDJ;
				end
				msswc_pkg::S_RDJ: begin
					state_q <= msswc_pkg::S_CMPJ;
				end
				msswc_pkg::S_CMPJ: begin
					if (precedes) begin
						if (cnt_pass_q) begin
							tally_q <= tally_inc;
						end else begin
							best_q <= j_q;
							bv_q <= rdata;
						end
					end
					if (j_q == n_m1_q) begin
						state_q <= msswc_pkg::S_ENDI;
					end else begin
						j_q <= j_q + AW'(1);
						state_q <= msswc_pkg::S_RDJ;
					end
				end
				msswc_pkg::S_ENDI, msswc_pkg::S_SWAP: begin
					if (state_q == msswc_pkg::S_ENDI && !cnt_pass_q
						&& best_q != i_q) begin
						if (algorithm_q == msswc_pkg::ALG_SELECTION) begin
							tally_q <= tally_inc;
						end
						state_q <= msswc_pkg::S_SWAP;
					end else if (last_i) begin
						i_q <= '0;
						if (cnt_pass_q) begin
							cnt_pass_q <= 1'b0;
							state_q <= msswc_pkg::S_RDI;
						end else begin
							state_q <= msswc_pkg::S_ORD;
						end
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= msswc_pkg::S_RDI;
					end
				end
				msswc_pkg::S_ORD: begin
					state_q <= msswc_pkg::S_OUT;
				end
				msswc_pkg::S_OUT: begin
					out_value_q <= rdata;
					out_last_q <= (k_q == n_m1_q);
					state_q <= msswc_pkg::S_HOLD;
				end
				msswc_pkg::S_HOLD: begin
					if (!out_stall) begin
						if (out_last_q) begin
							fill_q <= '0;
							ovf_q <= 1'b0;
							state_q <= msswc_pkg::S_LOAD;
						end else begin
							k_q <= k_q + AW'(1);
							state_q <= msswc_pkg::S_ORD;
						end
					end
				end
				default: begin
					state_q <= msswc_pkg::S_LOAD;
				end
			endcase
		end
	end

	assign in_stall = (state_q != msswc_pkg::S_LOAD);
	assign out_valid = (state_q == msswc_pkg::S_HOLD);
	assign sorted_value = out_value_q;
	assign exchange_count = tally_q;
	assign overflowed = ovf_q;
	assign last_out = out_last_q;

	`MSSC_ASSERT_NOW(a_no_overlap, !in_stall, !out_valid, "input taken while a result is pending")
	`MSSC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(MAX_ITEMS), "fill count beyond capacity")
	`MSSC_ASSERT_NEXT(a_set_cleared, out_xfer && last_out, fill_q == '0 && !ovf_q && !in_stall, "set not cleared after last transfer")

endmodule
